// ===== hdl/tsm3_pkg.sv =====
package tsm3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int THR_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int GEO_W = ($clog2(MAX_WIDTH + 2) > $clog2(MAX_HEIGHT + 2)) ?
                           $clog2(MAX_WIDTH + 2) : $clog2(MAX_HEIGHT + 2);
    localparam int DIM_W = (GEO_W > CFG_W) ? GEO_W : CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(2);

    localparam logic [THR_W-1:0] THR_RESET    = THR_W'(30);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_pix centre;
        logic border;
        logic last;
    } t_meta;

endpackage

// ===== hdl/tsm3_in_if.sv =====
interface tsm3_in_if;
    logic          valid;
    logic          ready;
    tsm3_pkg::t_pix pixel_in;
    logic          pad;

    modport source (output valid, output pixel_in, output pad, input ready);
    modport sink   (input valid, input pixel_in, input pad, output ready);
endinterface

// ===== hdl/tsm3_out_if.sv =====
interface tsm3_out_if;
    logic          valid;
    logic          ready;
    tsm3_pkg::t_pix pixel_out;
    logic          replaced;
    logic          frame_last;

    modport source (output valid, output pixel_out, output replaced, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_out, input replaced, input frame_last,
                    output ready);
endinterface

// ===== hdl/tsm3_ram.sv =====
module tsm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a shared address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tsm3_median.sv =====
module tsm3_median (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  tsm3_pkg::t_win   i_win,
    input  tsm3_pkg::t_meta  i_meta,
    output logic             o_vld,
    input  logic             i_rdy,
    output tsm3_pkg::t_pix   o_med,
    output tsm3_pkg::t_meta  o_meta
);

    function automatic tsm3_pkg::t_pix min2(input tsm3_pkg::t_pix a, input tsm3_pkg::t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic tsm3_pkg::t_pix max2(input tsm3_pkg::t_pix a, input tsm3_pkg::t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic tsm3_pkg::t_pix med3(input tsm3_pkg::t_pix a, input tsm3_pkg::t_pix b,
                                            input tsm3_pkg::t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // lo, mid, hi of each row
    logic [2:0][2:0][tsm3_pkg::PIX_W-1:0] r_c_srt;
    logic                                 r_c_vld;
    tsm3_pkg::t_meta                      r_c_meta;

    tsm3_pkg::t_pix  r_d_mx;
    tsm3_pkg::t_pix  r_d_md;
    tsm3_pkg::t_pix  r_d_mn;
    logic            r_d_vld;
    tsm3_pkg::t_meta r_d_meta;

    tsm3_pkg::t_pix  r_e_med;
    logic            r_e_vld;
    tsm3_pkg::t_meta r_e_meta;

    logic c_free;
    logic d_free;
    logic e_free;

    assign e_free = !r_e_vld || i_rdy;
    assign d_free = !r_d_vld || e_free;
    assign c_free = !r_c_vld || d_free;
    assign o_rdy  = c_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (c_free) begin
                r_c_vld <= i_vld;
            end
            if (d_free) begin
                r_d_vld <= r_c_vld;
            end
            if (e_free) begin
                r_e_vld <= r_d_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free) begin
            for (int r = 0; r < 3; r++) begin
                r_c_srt[r][0] <= min2(min2(i_win[3*r], i_win[3*r+1]), i_win[3*r+2]);
                r_c_srt[r][1] <= med3(i_win[3*r], i_win[3*r+1], i_win[3*r+2]);
                r_c_srt[r][2] <= max2(max2(i_win[3*r], i_win[3*r+1]), i_win[3*r+2]);
            end
            r_c_meta <= i_meta;
        end
        if (d_free) begin
            r_d_mx   <= max2(max2(r_c_srt[0][0], r_c_srt[1][0]), r_c_srt[2][0]);
            r_d_md   <= med3(r_c_srt[0][1], r_c_srt[1][1], r_c_srt[2][1]);
            r_d_mn   <= min2(min2(r_c_srt[0][2], r_c_srt[1][2]), r_c_srt[2][2]);
            r_d_meta <= r_c_meta;
        end
        if (e_free) begin
            r_e_med  <= med3(r_d_mx, r_d_md, r_d_mn);
            r_e_meta <= r_d_meta;
        end
    end

    assign o_vld  = r_e_vld;
    assign o_med  = r_e_med;
    assign o_meta = r_e_meta;

endmodule

// ===== hdl/threshold_switched_median_3x3_unit.sv =====
// Switching 3x3 median filter for a raster stream of 8-bit pixels.
// i_pix takes one transaction per pixel (pixel_in, pad); o_pix gives the
// filtered pixel with replaced and frame_last flags. Both channels use
// valid/ready. Results come one row plus one pixel behind the input: the
// first line_width+1 pixels of a frame give no result, and after the last
// pixel line_width+1 pad transactions flush the remaining results, the last
// one with frame_last set. Pads inside the frame are taken and dropped.
// A transaction that gives a result passes stage A, the window stage B, the
// median stages and the output register to o_pix. One transaction is taken
// per cycle; the line buffers are two 1-port-read/1-port-write RAMs, read on
// entry; the middle one is written as it is read, the upper one from stage A,
// with forwarding when consecutive pixels hit the same column. When o_pix
// stalls, the pipeline keeps taking input until every stage is full, then
// i_pix.ready drops. Configuration (threshold, line_width, frame_height) is
// written through i_cfg_* while the block is idle; a geometry write restarts
// the frame. Reset restores threshold 30, width 640 and height 480, empties
// the pipeline and restarts the frame; the line buffers are not cleared.
module threshold_switched_median_3x3_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tsm3_in_if.sink                           i_pix,
    tsm3_out_if.source                        o_pix,
    input  logic                              i_cfg_we,
    input  logic [tsm3_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tsm3_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int DW = tsm3_pkg::DIM_W;
    localparam int CW = tsm3_pkg::COL_W;

    logic [tsm3_pkg::THR_W-1:0] r_thr;
    logic [DW-1:0]              r_w;
    logic [DW-1:0]              r_h;
    logic [CW-1:0]              r_col;
    logic [DW-1:0]              r_row;
    logic [DW-1:0]              r_flush;

    logic [CW-1:0] n_col;
    logic [DW-1:0] n_row;
    logic [DW-1:0] n_flush;
    logic [DW-1:0] cfg_dim;

    logic           flushing;
    tsm3_pkg::t_pix pix_eff;
    logic [DW-1:0]  e_row;
    logic [DW-1:0]  e_col;
    logic [DW-1:0]  o_row;
    logic [DW-1:0]  o_col;
    logic [DW-1:0]  col_inc;
    logic           emit;
    logic           border;
    logic           last;
    logic [CW-1:0]  addr;

    logic take;
    logic a_free;
    logic b_free;
    logic a_go;

    // stage A: line buffer read data
    logic           r_a_vld;
    logic [CW-1:0]  r_a_col;
    tsm3_pkg::t_pix r_a_pix;
    logic           r_a_emit;
    logic           r_a_border;
    logic           r_a_last;
    logic           r_a_fwd;
    tsm3_pkg::t_pix r_a_fwd_top;
    tsm3_pkg::t_pix up_q;
    tsm3_pkg::t_pix mid_q;
    tsm3_pkg::t_pix top_a;

    // stage B: window
    tsm3_pkg::t_win r_win;
    logic           r_b_vld;
    logic           r_b_border;
    logic           r_b_last;
    tsm3_pkg::t_meta b_meta;

    logic            med_rdy;
    logic            med_vld;
    tsm3_pkg::t_pix  med;
    tsm3_pkg::t_meta med_meta;

    logic           o_free;
    tsm3_pkg::t_pix diff;
    logic           rep;
    logic           r_o_vld;
    tsm3_pkg::t_pix r_o_pix;
    logic           r_o_rep;
    logic           r_o_last;

    // geometry clamp
    always_comb begin
        cfg_dim = DW'(i_cfg_data);
        if (cfg_dim < tsm3_pkg::DIM_MIN) begin
            cfg_dim = tsm3_pkg::DIM_MIN;
        end else if ((i_cfg_idx == tsm3_pkg::CFG_LINE_WIDTH) &&
                     (cfg_dim > DW'(tsm3_pkg::MAX_WIDTH))) begin
            cfg_dim = DW'(tsm3_pkg::MAX_WIDTH);
        end else if ((i_cfg_idx != tsm3_pkg::CFG_LINE_WIDTH) &&
                     (cfg_dim > DW'(tsm3_pkg::MAX_HEIGHT))) begin
            cfg_dim = DW'(tsm3_pkg::MAX_HEIGHT);
        end
    end

    // position of this pixel and of the window centre
    always_comb begin
        flushing = r_row >= r_h;
        pix_eff  = flushing ? '0 : i_pix.pixel_in;
        if (flushing) begin
            if (r_flush >= r_w) begin
                e_row = r_h + DW'(1);
                e_col = '0;
            end else begin
                e_row = r_h;
                e_col = r_flush;
            end
        end else begin
            e_row = r_row;
            e_col = DW'(r_col);
        end
        if (e_col >= r_w) begin
            e_col = '0;
        end
        addr = e_col[CW-1:0];

        emit = (e_row >= DW'(2)) || ((e_row == DW'(1)) && (e_col != '0));
        if (e_col != '0) begin
            o_row = e_row - DW'(1);
            o_col = e_col - DW'(1);
        end else begin
            o_row = (e_row >= DW'(2)) ? e_row - DW'(2) : '0;
            o_col = r_w - DW'(1);
        end
        border = (o_row == '0) || (o_row == r_h - DW'(1)) ||
                 (o_col == '0) || (o_col == r_w - DW'(1));
        last   = (o_row == r_h - DW'(1)) && (o_col == r_w - DW'(1));

        col_inc = DW'(r_col) + DW'(1);
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (flushing) begin
            if (r_flush >= r_w) begin
                n_col   = '0;
                n_row   = '0;
                n_flush = '0;
            end else begin
                n_flush = r_flush + DW'(1);
            end
        end else if (col_inc >= r_w) begin
            n_col   = '0;
            n_row   = r_row + DW'(1);
            n_flush = '0;
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    assign b_free      = !r_b_vld || med_rdy;
    assign a_go        = r_a_vld && b_free;
    assign a_free      = !r_a_vld || b_free;
    assign i_pix.ready = a_free;
    assign take        = i_pix.valid && a_free && (flushing || !i_pix.pad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tsm3_pkg::THR_RESET;
            r_w     <= tsm3_pkg::WIDTH_RESET;
            r_h     <= tsm3_pkg::HEIGHT_RESET;
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsm3_pkg::CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[tsm3_pkg::THR_W-1:0];
                end
                tsm3_pkg::CFG_LINE_WIDTH: begin
                    r_w     <= cfg_dim;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_flush <= '0;
                end
                tsm3_pkg::CFG_FRAME_HEIGHT: begin
                    r_h     <= cfg_dim;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_flush <= '0;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // middle line: read old value and write new pixel in the same cycle
    tsm3_ram #(
        .WIDTH (tsm3_pkg::PIX_W),
        .DEPTH (tsm3_pkg::MAX_WIDTH)
    ) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (addr),
        .i_wdata (pix_eff),
        .i_re    (take),
        .i_raddr (addr),
        .o_rdata (mid_q)
    );

    // upper line: written back from stage A with the old middle value
    tsm3_ram #(
        .WIDTH (tsm3_pkg::PIX_W),
        .DEPTH (tsm3_pkg::MAX_WIDTH)
    ) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (r_a_vld),
        .i_waddr (r_a_col),
        .i_wdata (mid_q),
        .i_re    (take),
        .i_raddr (addr),
        .o_rdata (up_q)
    );

    assign top_a = r_a_fwd ? r_a_fwd_top : up_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_vld <= take;
            end
            if (b_free) begin
                r_b_vld <= r_a_vld && r_a_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_col     <= addr;
            r_a_pix     <= pix_eff;
            r_a_emit    <= emit;
            r_a_border  <= border;
            r_a_last    <= last;
            r_a_fwd     <= r_a_vld && (r_a_col == addr);
            r_a_fwd_top <= mid_q;
        end
        if (a_go) begin
            for (int r = 0; r < 3; r++) begin
                r_win[3*r]   <= r_win[3*r+1];
                r_win[3*r+1] <= r_win[3*r+2];
            end
            r_win[2]   <= top_a;
            r_win[5]   <= mid_q;
            r_win[8]   <= r_a_pix;
            r_b_border <= r_a_border;
            r_b_last   <= r_a_last;
        end
    end

    always_comb begin
        b_meta.centre = r_win[4];
        b_meta.border = r_b_border;
        b_meta.last   = r_b_last;
    end

    tsm3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .o_rdy   (med_rdy),
        .i_win   (r_win),
        .i_meta  (b_meta),
        .o_vld   (med_vld),
        .i_rdy   (o_free),
        .o_med   (med),
        .o_meta  (med_meta)
    );

    assign o_free = !r_o_vld || o_pix.ready;
    assign diff   = (med > med_meta.centre) ? med - med_meta.centre : med_meta.centre - med;
    assign rep    = !med_meta.border && (diff > r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_free) begin
            r_o_vld <= med_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_o_pix  <= rep ? med : med_meta.centre;
            r_o_rep  <= rep;
            r_o_last <= med_meta.last;
        end
    end

    assign o_pix.valid      = r_o_vld;
    assign o_pix.pixel_out  = r_o_pix;
    assign o_pix.replaced   = r_o_rep;
    assign o_pix.frame_last = r_o_last;

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_h)
        else $error("row count beyond frame height");

    a_flush_only_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != '0) |-> (r_row >= r_h))
        else $error("flush count running inside the frame");

    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !b_free) |-> (!take ##1 (r_a_vld && $stable(r_a_col))))
        else $error("line buffer stage lost its item under stall");

    a_last_not_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_last) |-> !r_o_rep)
        else $error("corner pixel replaced");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int          SETTLE_CYCLES  = 10;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_ITEMS   = 440;
    localparam int          HEAVY_PCT      = 61;
    localparam int          LIGHT_PCT      = 8;
    localparam int unsigned WHOLE_FRAME    = 32'hFFFF_FFFF;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        tsm3_pkg::t_pix pixel;
        logic           replaced;
        logic           last;
    } t_filtered_px;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tsm3_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tsm3_pkg::CFG_W-1:0]     i_cfg_data;

    tsm3_in_if  pix_in ();
    tsm3_out_if pix_out ();

    threshold_switched_median_3x3_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in),
        .o_pix      (pix_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // filter predictor state
    logic [tsm3_pkg::THR_W-1:0] thr_reg;
    logic [tsm3_pkg::CFG_W-1:0] width_reg;
    logic [tsm3_pkg::CFG_W-1:0] height_reg;
    tsm3_pkg::t_pix             upper_row  [tsm3_pkg::MAX_WIDTH];
    tsm3_pkg::t_pix             middle_row [tsm3_pkg::MAX_WIDTH];
    tsm3_pkg::t_pix             window_px  [9];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                flush_pos;

    t_filtered_px pending_px[$];
    int           error_count  = 0;
    int unsigned  items_taken  = 0;
    int           quiet_cycles = 0;
    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    int           scene_level  = 128;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic tsm3_pkg::t_pix median_of_nine(input tsm3_pkg::t_pix px [9]);
        tsm3_pkg::t_pix s [9];
        tsm3_pkg::t_pix v;
        int             j;
        s = px;
        for (int i = 1; i < 9; i++) begin
            v = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > v) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = v;
        end
        return s[4];
    endfunction

    function automatic void reset_filter_state();
        thr_reg    = tsm3_pkg::THR_RESET;
        width_reg  = tsm3_pkg::WIDTH_RESET;
        height_reg = tsm3_pkg::HEIGHT_RESET;
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (window_px[i]) window_px[i] = '0;
        col_pos   = 0;
        row_pos   = 0;
        flush_pos = 0;
    endfunction

    function automatic void apply_reg_write(input logic [tsm3_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [tsm3_pkg::CFG_W-1:0] data);
        case (idx)
            tsm3_pkg::CFG_THRESHOLD: begin
                thr_reg = data[tsm3_pkg::THR_W-1:0];
            end
            tsm3_pkg::CFG_LINE_WIDTH, tsm3_pkg::CFG_FRAME_HEIGHT: begin
                if (idx == tsm3_pkg::CFG_LINE_WIDTH) width_reg = data;
                else height_reg = data;
                col_pos   = 0;
                row_pos   = 0;
                flush_pos = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic void filter_take(input tsm3_pkg::t_pix pix_in_val, input logic pad_in);
        int unsigned    w, h, erow, ecol, orow, ocol, delta;
        logic           flushing, emit, swap;
        tsm3_pkg::t_pix pix, top, mid, centre, med, res;
        t_filtered_px   r;
        w        = clamp_dim(width_reg, tsm3_pkg::MAX_WIDTH);
        h        = clamp_dim(height_reg, tsm3_pkg::MAX_HEIGHT);
        flushing = (row_pos >= h);
        if (!flushing && pad_in) return;
        items_taken++;
        pix = pix_in_val;
        if (flushing) begin
            pix = '0;
            if (flush_pos >= w) begin
                erow = h + 1;
                ecol = 0;
            end else begin
                erow = h;
                ecol = flush_pos;
            end
        end else begin
            erow = row_pos;
            ecol = col_pos;
        end
        if (ecol >= w) ecol = 0;

        top             = upper_row[ecol];
        mid             = middle_row[ecol];
        upper_row[ecol] = mid;
        middle_row[ecol] = pix;
        for (int k = 0; k < 3; k++) begin
            window_px[k * 3]     = window_px[k * 3 + 1];
            window_px[k * 3 + 1] = window_px[k * 3 + 2];
        end
        window_px[2] = top;
        window_px[5] = mid;
        window_px[8] = pix;

        // centre lags one row plus one pixel
        emit = (erow >= 2) || (erow == 1 && ecol >= 1);
        if (ecol >= 1) begin
            orow = erow - 1;
            ocol = ecol - 1;
        end else begin
            orow = (erow >= 2) ? erow - 2 : 0;
            ocol = w - 1;
        end

        if (flushing) begin
            flush_pos++;
            if (flush_pos > w) begin
                flush_pos = 0;
                row_pos   = 0;
                col_pos   = 0;
            end
        end else begin
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) flush_pos = 0;
            end
        end

        if (!emit) return;
        centre = window_px[4];
        res    = centre;
        swap   = 1'b0;
        if (orow != 0 && orow != h - 1 && ocol != 0 && ocol != w - 1) begin
            med   = median_of_nine(window_px);
            delta = (med > centre) ? med - centre : centre - med;
            if (delta > thr_reg) begin
                res  = med;
                swap = 1'b1;
            end
        end
        r.pixel    = res;
        r.replaced = swap;
        r.last     = (orow == h - 1 && ocol == w - 1);
        pending_px.push_back(r);
    endfunction

    function automatic tsm3_pkg::t_pix scene_pixel();
        int v;
        if ($urandom_range(49) == 0) scene_level = $urandom_range(255);
        if ($urandom_range(99) < 15) return tsm3_pkg::t_pix'($urandom_range(255));
        v = scene_level + int'($urandom_range(12)) - 6;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return tsm3_pkg::t_pix'(v);
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        tx_idle_pct  = (mode == IDLE_SENDER)   ? HEAVY_PCT :
                       (mode == IDLE_BOTH)     ? LIGHT_PCT : 0;
        rx_stall_pct = (mode == IDLE_RECEIVER) ? HEAVY_PCT :
                       (mode == IDLE_BOTH)     ? LIGHT_PCT : 0;
    endtask

    task automatic push_pixel(input tsm3_pkg::t_pix pix, input logic pad);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.pixel_in <= pix;
        pix_in.pad      <= pad;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        filter_take(pix, pad);
        @(negedge i_clk);
    endtask

    task automatic settle();
        pix_in.valid <= 1'b0;
        while (pending_px.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tsm3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsm3_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        apply_reg_write(idx, data);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned thr, input int unsigned width,
                             input int unsigned height);
        settle();
        write_reg(tsm3_pkg::CFG_THRESHOLD, tsm3_pkg::CFG_W'(thr));
        write_reg(tsm3_pkg::CFG_LINE_WIDTH, tsm3_pkg::CFG_W'(width));
        write_reg(tsm3_pkg::CFG_FRAME_HEIGHT, tsm3_pkg::CFG_W'(height));
    endtask

    // cut below the pixel count leaves the frame unfinished and unflushed
    task automatic send_frame(input int unsigned width, input int unsigned height,
                              input int unsigned cut);
        int unsigned w, h, total;
        w     = clamp_dim(width, tsm3_pkg::MAX_WIDTH);
        h     = clamp_dim(height, tsm3_pkg::MAX_HEIGHT);
        total = w * h;
        for (int unsigned n = 0; n < total && n < cut; n++) begin
            if ($urandom_range(99) < 3)
                push_pixel(tsm3_pkg::t_pix'($urandom_range(255)), 1'b1);
            push_pixel(scene_pixel(), 1'b0);
        end
        if (cut < total) return;
        for (int unsigned n = 0; n <= w; n++) begin
            if ($urandom_range(9) == 0) push_pixel(scene_pixel(), 1'b0);
            else push_pixel(tsm3_pkg::t_pix'($urandom_range(255)), 1'b1);
        end
    endtask

    // reset threshold kept; centre sits exactly on the threshold
    task automatic test_threshold_at_limit();
        set_idling(IDLE_NONE);
        settle();
        write_reg(tsm3_pkg::CFG_LINE_WIDTH, tsm3_pkg::CFG_W'(3));
        write_reg(tsm3_pkg::CFG_FRAME_HEIGHT, tsm3_pkg::CFG_W'(3));
        for (int n = 0; n < 9; n++) begin
            push_pixel((n == 4) ? tsm3_pkg::t_pix'(30) : tsm3_pkg::t_pix'(0), 1'b0);
            if (n == 3) push_pixel(tsm3_pkg::t_pix'(255), 1'b1);
        end
        push_pixel(tsm3_pkg::t_pix'(0), 1'b1);
        push_pixel(tsm3_pkg::t_pix'(0), 1'b1);
        push_pixel(tsm3_pkg::t_pix'(77), 1'b0);
        push_pixel(tsm3_pkg::t_pix'(0), 1'b1);
    endtask

    // geometry below the minimum, zero threshold, one-step difference
    task automatic test_clamped_geometry();
        set_idling(IDLE_BOTH);
        configure(0, 1, 2);
        for (int n = 0; n < 9; n++)
            push_pixel((n == 4) ? tsm3_pkg::t_pix'(254) : tsm3_pkg::t_pix'(255), 1'b0);
        for (int n = 0; n < 4; n++) push_pixel(tsm3_pkg::t_pix'(255), 1'b1);
    endtask

    // widest rows, abandoned within the first row by the next geometry write
    task automatic test_widest_rows();
        set_idling(IDLE_BOTH);
        configure($urandom_range(40), 2047, 1024);
        send_frame(2047, 1024, 40);
    endtask

    // tallest frame, first rows only
    task automatic test_tallest_frame();
        set_idling(IDLE_SENDER);
        configure($urandom_range(40), 3, 2047);
        send_frame(3, 2047, 60);
    endtask

    task automatic test_random_frames();
        t_idle_mode  modes [4];
        int unsigned goal, thr, w, h, frames;
        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        foreach (modes[m]) begin
            set_idling(modes[m]);
            goal = items_taken + RANDOM_ITEMS / 4;
            while (items_taken < goal) begin
                case ($urandom_range(5))
                    0:       thr = 0;
                    1:       thr = 255;
                    default: thr = $urandom_range(60);
                endcase
                w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
                h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
                configure(thr, w, h);
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    if (f == frames - 1 && $urandom_range(7) == 0)
                        send_frame(w, h, $urandom_range(1, 20));
                    else
                        send_frame(w, h, WHOLE_FRAME);
                end
            end
        end
    endtask

    initial begin
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pix_out.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_filtered_px want;
        if (i_rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (pending_px.size() == 0) begin
                $error("unexpected transaction: pixel_out %0d", pix_out.pixel_out);
                error_count++;
            end else begin
                want = pending_px.pop_front();
                if (pix_out.pixel_out !== want.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel, pix_out.pixel_out);
                    error_count++;
                end
                if (pix_out.replaced !== want.replaced) begin
                    $error("replaced: expected %0b, got %0b", want.replaced, pix_out.replaced);
                    error_count++;
                end
                if (pix_out.frame_last !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, pix_out.frame_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
                (pix_out.valid === 1'b1 && pix_out.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = tsm3_pkg::CFG_THRESHOLD;
        i_cfg_data      = '0;
        pix_in.valid    = 1'b0;
        pix_in.pixel_in = '0;
        pix_in.pad      = 1'b0;
        reset_filter_state();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_threshold_at_limit();
        test_clamped_geometry();
        test_random_frames();
        test_widest_rows();
        test_tallest_frame();
        settle();

        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
